// ----- sv/nbc_pkg.sv -----
// Shared types and constants for the symbol-pair naive Bayes classifier.
// No dependencies; the other files that use it refer to it by scoped names.
package nbc_pkg;

	// Default sizes handed to the top level parameters
	localparam int KEY_BITS_DEF        = 16;
	localparam int COUNT_BITS_DEF      = 32;
	localparam int SCORE_FRAC_BITS_DEF = 32;

	// Fixed constants of the scheme
	localparam logic [7:0] MALE_LABEL = 8'd208;
	localparam int         PAIR_SHIFT = 8;
	localparam int         SCORE_BITS = 64;
	localparam int         CMD_DEPTH  = 2;

	// Arithmetic unit operation codes
	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

	// One input word
	typedef struct packed {
		logic [7:0] name_byte;
		logic [7:0] gender_byte;
		logic       last;
	} item_t;

	// One result word
	typedef struct packed {
		logic [SCORE_BITS-1:0] male_score;
		logic [SCORE_BITS-1:0] female_score;
		logic                  no_data;
	} result_t;

	// Command flags passed from the front end to the back end
	typedef struct packed {
		logic has_key;
		logic male;
		logic predict;
		logic last;
	} cmd_t;

	localparam int CMD_BITS = $bits(cmd_t);

endpackage

// ----- sv/nbc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nbc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/nbc_fifo.sv -----
// Short command queue between the front end and the back end.
// Depends on nbc_pkg for its depth.
module nbc_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int DEPTH = nbc_pkg::CMD_DEPTH;
	localparam int PW    = $clog2(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [PW:0]      count_q;

	assign full  = (count_q == (PW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = slot_q[rptr_q];

	// Store pushed words
	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/nbc_muldiv.sv -----
// Bit-serial shift-add multiplier and restoring divider, one bit per cycle.
// Depends on nbc_pkg for the operation codes.
module nbc_muldiv #(
	parameter int NUM_W = 129,
	parameter int MUL_W = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             op,
	input  logic [NUM_W-1:0] a,
	input  logic [NUM_W-1:0] b,
	output logic             done,
	output logic [NUM_W-1:0] res
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic             op_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] acc_q;
	logic [NUM_W-1:0] sh_q;
	logic [NUM_W-1:0] b_q;
	logic [NUM_W:0]   trial;
	logic             ge;

	// Divider trial subtraction
	always_comb begin
		trial = {acc_q, sh_q[NUM_W-1]};
		ge    = (trial >= {1'b0, b_q});
	end

	assign done = done_q;
	assign res  = (op_q == nbc_pkg::OP_DIV) ? sh_q : acc_q;

	// Datapath: load on start, then one step per cycle
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			acc_q <= '0;
			sh_q  <= a;
			b_q   <= b;
		end else if (busy_q) begin
			if (op_q == nbc_pkg::OP_MUL) begin
				if (b_q[0]) begin
					acc_q <= acc_q + sh_q;
				end
				sh_q <= {sh_q[NUM_W-2:0], 1'b0};
				b_q  <= {1'b0, b_q[NUM_W-1:1]};
			end else begin
				acc_q <= ge ? NUM_W'(trial - {1'b0, b_q}) : trial[NUM_W-1:0];
				sh_q  <= {sh_q[NUM_W-2:0], ge};
			end
		end
	end

	// Control: step count and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= nbc_pkg::OP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				op_q   <= op;
				cnt_q  <= (op == nbc_pkg::OP_MUL) ? CNT_W'(MUL_W - 1) : CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

endmodule

// ----- sv/nbc_front.sv -----
// Front end: holds the mode register, pairs name bytes into keys and
// classifies each accepted word into a command. Depends on nbc_pkg.
module nbc_front #(
	parameter int KEY_BITS = nbc_pkg::KEY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  nbc_pkg::item_t      item,
	input  logic                cfg_we,
	input  logic                cfg_mode,
	output nbc_pkg::cmd_t       cmd,
	output logic [KEY_BITS-1:0] key
);

	logic       mode_q;
	logic [7:0] held_q;
	logic       held_valid_q;
	logic [15:0] hi_ext;
	logic [15:0] lo_ext;
	logic [15:0] pair_key;

	// Form the key from the held byte and this one, or this byte alone
	always_comb begin
		hi_ext   = {{8{held_q[7]}}, held_q};
		lo_ext   = {{8{item.name_byte[7]}}, item.name_byte};
		pair_key = (hi_ext << nbc_pkg::PAIR_SHIFT) + lo_ext;
		key      = held_valid_q ? pair_key[KEY_BITS-1:0] : lo_ext[KEY_BITS-1:0];
		cmd.has_key = held_valid_q || item.last;
		cmd.male    = (item.gender_byte == nbc_pkg::MALE_LABEL);
		cmd.predict = mode_q;
		cmd.last    = item.last;
	end

	// Hold the first byte of a pair
	always_ff @(posedge clk) begin
		if (accept && !held_valid_q && !item.last) begin
			held_q <= item.name_byte;
		end
	end

	// Track pairing and the mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			held_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_mode;
			end
			if (accept) begin
				held_valid_q <= !held_valid_q && !item.last;
			end
		end
	end

endmodule

// ----- sv/nbc_back.sv -----
// Back end: count tables, totals, running scores and the sequencer that
// drives the serial arithmetic unit. Depends on nbc_pkg, nbc_ram, nbc_muldiv.
module nbc_back #(
	parameter int KEY_BITS        = nbc_pkg::KEY_BITS_DEF,
	parameter int COUNT_BITS      = nbc_pkg::COUNT_BITS_DEF,
	parameter int SCORE_FRAC_BITS = nbc_pkg::SCORE_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_empty,
	input  nbc_pkg::cmd_t       cmd,
	input  logic [KEY_BITS-1:0] key,
	output logic                cmd_rd,
	input  logic                pop,
	output logic                res_valid,
	output nbc_pkg::result_t    result,
	output logic                clearing
);

	localparam int CW    = COUNT_BITS;
	localparam int AW    = COUNT_BITS + 1;
	localparam int SB    = nbc_pkg::SCORE_BITS;
	localparam int NUM_W = SB + 2 * COUNT_BITS + 1;
	localparam int DEPTH = 1 << KEY_BITS;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_READ  = 4'd2;
	localparam logic [3:0] ST_PRIOR = 4'd3;
	localparam logic [3:0] ST_MUL1  = 4'd4;
	localparam logic [3:0] ST_MUL2  = 4'd5;
	localparam logic [3:0] ST_MUL3  = 4'd6;
	localparam logic [3:0] ST_DIV   = 4'd7;
	localparam logic [3:0] ST_EMIT  = 4'd8;

	logic [3:0]          state_q;
	logic [KEY_BITS-1:0] clr_q;
	nbc_pkg::cmd_t       cmd_q;
	logic [KEY_BITS-1:0] key_q;
	logic [CW-1:0]       mc_q, fc_q, mt_q, ft_q;
	logic                pair_ok_q;
	logic [SB-1:0]       run_m_q, run_f_q;
	logic                started_q;
	logic                cls_q;
	logic                issued_q;
	logic [NUM_W-1:0]    t_q, den_q;
	logic                out_valid_q;
	nbc_pkg::result_t    out_q;

	logic [CW-1:0]    rd_m, rd_f;
	logic             we_m, we_f;
	logic [CW-1:0]    wd_m, wd_f;
	logic [KEY_BITS-1:0] waddr;
	logic [AW-1:0]    all_sum;
	logic [AW-1:0]    pair_sum;
	logic             is_op;
	logic             md_start, md_op, md_done;
	logic [NUM_W-1:0] md_a, md_b, md_res;
	logic [SB-1:0]    quo_sat;
	logic [CW-1:0]    tot_c, cnt_c;
	logic [SB-1:0]    run_c;
	logic             emit_go;

	assign clearing  = (state_q == ST_CLEAR);
	assign res_valid = out_valid_q;
	assign result    = out_q;
	assign cmd_rd    = (state_q == ST_IDLE) && !cmd_empty;
	assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || pop);

	// Select operands for the current class
	always_comb begin
		all_sum  = AW'(mt_q) + AW'(ft_q);
		pair_sum = AW'(mc_q) + AW'(fc_q);
		tot_c    = cls_q ? ft_q : mt_q;
		cnt_c    = cls_q ? fc_q : mc_q;
		run_c    = cls_q ? run_f_q : run_m_q;
		quo_sat  = (md_res[NUM_W-1:SB] != '0) ? '1 : md_res[SB-1:0];
		is_op    = (state_q == ST_PRIOR) || (state_q == ST_MUL1) || (state_q == ST_MUL2) ||
		           (state_q == ST_MUL3) || (state_q == ST_DIV);
		md_start = is_op && !issued_q;
		md_op    = nbc_pkg::OP_MUL;
		md_a     = '0;
		md_b     = '0;
		unique case (state_q)
			ST_PRIOR: begin
				md_op = nbc_pkg::OP_DIV;
				md_a  = NUM_W'(tot_c) << SCORE_FRAC_BITS;
				md_b  = NUM_W'(all_sum);
			end
			ST_MUL1: begin
				md_a = NUM_W'(run_c);
				md_b = NUM_W'(cnt_c);
			end
			ST_MUL2: begin
				md_a = t_q;
				md_b = NUM_W'(all_sum);
			end
			ST_MUL3: begin
				md_a = NUM_W'(tot_c);
				md_b = NUM_W'(pair_sum);
			end
			ST_DIV: begin
				md_op = nbc_pkg::OP_DIV;
				md_a  = t_q;
				md_b  = den_q;
			end
			default: begin
				md_op = nbc_pkg::OP_MUL;
			end
		endcase
	end

	// Table writes: clearing pass or a training update
	always_comb begin
		we_m  = 1'b0;
		we_f  = 1'b0;
		wd_m  = '0;
		wd_f  = '0;
		waddr = key_q;
		if (state_q == ST_CLEAR) begin
			we_m  = 1'b1;
			we_f  = 1'b1;
			waddr = clr_q;
		end else if (state_q == ST_READ && !cmd_q.predict && cmd_q.has_key) begin
			we_m = cmd_q.male;
			we_f = !cmd_q.male;
			wd_m = (rd_m == '1) ? rd_m : rd_m + 1'b1;
			wd_f = (rd_f == '1) ? rd_f : rd_f + 1'b1;
		end
	end

	nbc_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_male_ram (
		.clk(clk), .we(we_m), .waddr(waddr), .wdata(wd_m),
		.re(cmd_rd), .raddr(key), .rdata(rd_m)
	);

	nbc_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_female_ram (
		.clk(clk), .we(we_f), .waddr(waddr), .wdata(wd_f),
		.re(cmd_rd), .raddr(key), .rdata(rd_f)
	);

	nbc_muldiv #(.NUM_W(NUM_W), .MUL_W(AW)) u_muldiv (
		.clk(clk), .arst_n(arst_n), .start(md_start), .op(md_op),
		.a(md_a), .b(md_b), .done(md_done), .res(md_res)
	);

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd_rd) begin
			cmd_q <= cmd;
			key_q <= key;
		end
		if (state_q == ST_READ) begin
			mc_q      <= rd_m;
			fc_q      <= rd_f;
			pair_ok_q <= (rd_m != '0) && (rd_f != '0);
		end
		if (md_done && state_q == ST_MUL1) begin
			t_q <= md_res;
		end
		if (md_done && state_q == ST_MUL2) begin
			t_q <= md_res;
		end
		if (md_done && state_q == ST_MUL3) begin
			den_q <= md_res;
		end
		if (emit_go) begin
			out_q.male_score   <= (all_sum == '0) ? '0 : run_m_q;
			out_q.female_score <= (all_sum == '0) ? '0 : run_f_q;
			out_q.no_data      <= (all_sum == '0);
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			mt_q        <= '0;
			ft_q        <= '0;
			run_m_q     <= '0;
			run_f_q     <= '0;
			started_q   <= 1'b0;
			cls_q       <= 1'b0;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (md_start) begin
				issued_q <= 1'b1;
			end
			if (md_done) begin
				issued_q <= 1'b0;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (!cmd_empty) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					cls_q <= 1'b0;
					if (!cmd_q.predict) begin
						started_q <= 1'b0;
						if (cmd_q.has_key) begin
							if (cmd_q.male) begin
								mt_q <= (mt_q == '1) ? mt_q : mt_q + 1'b1;
							end else begin
								ft_q <= (ft_q == '1) ? ft_q : ft_q + 1'b1;
							end
						end
						state_q <= ST_IDLE;
					end else if (cmd_q.has_key && all_sum != '0) begin
						if (!started_q) begin
							started_q <= 1'b1;
							state_q   <= ST_PRIOR;
						end else if (rd_m != '0 && rd_f != '0) begin
							state_q <= ST_MUL1;
						end else begin
							state_q <= cmd_q.last ? ST_EMIT : ST_IDLE;
						end
					end else begin
						state_q <= cmd_q.last ? ST_EMIT : ST_IDLE;
					end
				end
				ST_PRIOR: begin
					if (md_done) begin
						if (cls_q) begin
							run_f_q <= quo_sat;
							cls_q   <= 1'b0;
							if (pair_ok_q) begin
								state_q <= ST_MUL1;
							end else begin
								state_q <= cmd_q.last ? ST_EMIT : ST_IDLE;
							end
						end else begin
							run_m_q <= quo_sat;
							cls_q   <= 1'b1;
						end
					end
				end
				ST_MUL1: begin
					if (md_done) begin
						state_q <= ST_MUL2;
					end
				end
				ST_MUL2: begin
					if (md_done) begin
						state_q <= ST_MUL3;
					end
				end
				ST_MUL3: begin
					if (md_done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (md_done) begin
						if (cls_q) begin
							run_f_q <= quo_sat;
							cls_q   <= 1'b0;
							state_q <= cmd_q.last ? ST_EMIT : ST_IDLE;
						end else begin
							run_m_q <= quo_sat;
							cls_q   <= 1'b1;
							state_q <= ST_MUL1;
						end
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						started_q <= 1'b0;
						run_m_q   <= '0;
						run_f_q   <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sv/naive_bayes_symbol_pair_classifier_top.sv -----
// Two-class naive Bayes classifier over byte-pair keys. Bytes of a name are
// pushed one word at a time; successive bytes pair up into a key (an odd last
// byte stands alone). In train mode (mode 0) each key raises its class count
// and total; in classify mode (mode 1) the last byte yields one result word
// with unsigned fixed-point male and female scores. After reset both count
// tables are cleared, one entry per cycle, all 2^KEY_BITS entries (65536 at
// the defaults), during which full stays high. A train word in the back end
// passes from idle through the read state and back. A classify key runs on
// one bit-serial multiply/divide unit: the first key of a name adds two prior
// divisions, and every key whose two counts are nonzero costs two passes of
// three multiplies plus one division. A two-entry command queue and an
// output register let input and output sides stall independently.
// Depends on nbc_pkg, nbc_front, nbc_fifo, nbc_back.
module naive_bayes_symbol_pair_classifier_top #(
	parameter int KEY_BITS        = nbc_pkg::KEY_BITS_DEF,
	parameter int COUNT_BITS      = nbc_pkg::COUNT_BITS_DEF,
	parameter int SCORE_FRAC_BITS = nbc_pkg::SCORE_FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  nbc_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output nbc_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_data
);

	localparam int QW = nbc_pkg::CMD_BITS + KEY_BITS;

	logic                accept;
	logic                q_full, q_empty, q_rd;
	logic                clearing;
	logic                res_valid;
	nbc_pkg::cmd_t       f_cmd, b_cmd;
	logic [KEY_BITS-1:0] f_key, b_key;
	logic [QW-1:0]       q_rdata;

	// Handshakes
	assign cfg_ready = 1'b1;
	assign full      = q_full || clearing;
	assign accept    = push && !full;
	assign empty     = !res_valid;
	assign b_cmd     = nbc_pkg::cmd_t'(q_rdata[QW-1:KEY_BITS]);
	assign b_key     = q_rdata[KEY_BITS-1:0];

	nbc_front #(.KEY_BITS(KEY_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .item(item),
		.cfg_we(cfg_valid && cfg_ready), .cfg_mode(cfg_data),
		.cmd(f_cmd), .key(f_key)
	);

	nbc_fifo #(.WIDTH(QW)) u_cmdq (
		.clk(clk), .arst_n(arst_n), .wr(accept), .wdata({f_cmd, f_key}),
		.rd(q_rd), .rdata(q_rdata), .full(q_full), .empty(q_empty)
	);

	nbc_back #(
		.KEY_BITS(KEY_BITS), .COUNT_BITS(COUNT_BITS), .SCORE_FRAC_BITS(SCORE_FRAC_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_empty(q_empty), .cmd(b_cmd), .key(b_key),
		.cmd_rd(q_rd), .pop(pop), .res_valid(res_valid), .result(result),
		.clearing(clearing)
	);

endmodule

// ----- sv/nbc_checker.sv -----
// Port-level checks for the classifier top, attached by the bind below.
// Depends on nbc_pkg and naive_bayes_symbol_pair_classifier_top.
module nbc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             full,
	input logic             empty,
	input logic             pop,
	input nbc_pkg::result_t result
);

	// A waiting result neither vanishes nor changes until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed or dropped while waiting");

	// An untrained result carries zero scores
	a_no_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.no_data |-> result.male_score == '0 && result.female_score == '0)
		else $error("no_data result with nonzero score");

	// Table clearing keeps the input closed right after reset
	a_clear_blocks: assert property (@(posedge clk)
		arst_n && !$past(arst_n) |-> full)
		else $error("input open during table clearing");

endmodule

bind naive_bayes_symbol_pair_classifier_top nbc_checker u_nbc_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking bench for the symbol-pair naive Bayes classifier top level.
// Trains and classifies names in alternating phases against an in-bench score
// model; depends on nbc_pkg and naive_bayes_symbol_pair_classifier_top.
module tb_top;

	localparam int LIMIT_CYCLES = 4000000;
	localparam int SETTLE       = 1500;
	localparam int LONG_HOLD    = 4000;

	logic             clk;
	logic             arst_n;
	logic             push;
	logic             full;
	nbc_pkg::item_t   item;
	logic             empty;
	logic             pop;
	nbc_pkg::result_t result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic             cfg_data;

	naive_bayes_symbol_pair_classifier_top DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Score model state
	bit [31:0] male_tab [65536];
	bit [31:0] female_tab [65536];
	bit [31:0] male_sum, female_sum;
	bit [7:0]  pend_byte;
	bit        pend_ok;
	bit [63:0] male_acc, female_acc;
	bit        acc_live;
	bit        cur_mode;

	nbc_pkg::item_t   name_q [$];
	nbc_pkg::result_t score_q [$];
	int  fails;
	int  cycles;
	bit  tx_pause;
	bit  rx_hold_req;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic bit [31:0] sat_bump(bit [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// Floor of run * cnt * all / (tot * pair), clamped to 64 bits
	function automatic bit [63:0] scaled(bit [63:0] run, bit [31:0] cnt, bit [32:0] all,
			bit [31:0] tot, bit [32:0] pair);
		bit [191:0] n, d, q;
		n = 192'(run) * 192'(cnt) * 192'(all);
		d = 192'(tot) * 192'(pair);
		q = n / d;
		return (q[191:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
	endfunction

	function automatic bit [63:0] prior_of(bit [31:0] tot, bit [32:0] all);
		bit [191:0] q;
		q = (192'(tot) << 32) / 192'(all);
		return (q[191:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
	endfunction

	// Advance the model by one accepted word
	function automatic void score_word(nbc_pkg::item_t w);
		bit        got_key;
		bit [15:0] k;
		bit [32:0] all;
		bit [31:0] mc, fc;
		nbc_pkg::result_t r;
		got_key = 0;
		k = '0;
		if (pend_ok) begin
			k = ({{8{pend_byte[7]}}, pend_byte} << 8) + {{8{w.name_byte[7]}}, w.name_byte};
			pend_ok = 0;
			got_key = 1;
		end else if (w.last) begin
			k = {{8{w.name_byte[7]}}, w.name_byte};
			got_key = 1;
		end else begin
			pend_byte = w.name_byte;
			pend_ok = 1;
		end
		if (cur_mode == 1'b0) begin
			acc_live = 0;
			if (got_key) begin
				if (w.gender_byte == nbc_pkg::MALE_LABEL) begin
					male_tab[k] = sat_bump(male_tab[k]);
					male_sum = sat_bump(male_sum);
				end else begin
					female_tab[k] = sat_bump(female_tab[k]);
					female_sum = sat_bump(female_sum);
				end
			end
			if (w.last) pend_ok = 0;
			return;
		end
		all = 33'(male_sum) + 33'(female_sum);
		if (got_key && all != 0) begin
			mc = male_tab[k];
			fc = female_tab[k];
			if (!acc_live) begin
				male_acc = prior_of(male_sum, all);
				female_acc = prior_of(female_sum, all);
				acc_live = 1;
			end
			if (mc != 0 && fc != 0) begin
				male_acc = scaled(male_acc, mc, all, male_sum, 33'(mc) + 33'(fc));
				female_acc = scaled(female_acc, fc, all, female_sum, 33'(mc) + 33'(fc));
			end
		end
		if (!w.last) return;
		r.male_score = (all == 0) ? '0 : male_acc;
		r.female_score = (all == 0) ? '0 : female_acc;
		r.no_data = (all == 0);
		score_q.push_back(r);
		acc_live = 0;
		pend_ok = 0;
		male_acc = 0;
		female_acc = 0;
	endfunction

	// Driver: offer queued words, random gap after each accepted word
	int tx_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 0;
			item <= '0;
			tx_gap = 0;
		end else if (!(push && full)) begin
			if (push) begin
				score_word(item);
				tx_gap = $urandom_range(0, 6);
				if ($urandom_range(0, 9) < 3) tx_gap = 0;
			end
			if (tx_gap > 0) begin
				tx_gap--;
				push <= 0;
			end else if (name_q.size() > 0 && !tx_pause) begin
				push <= 1;
				item <= name_q.pop_front();
			end else begin
				push <= 0;
			end
		end
	end

	// Monitor: check each popped word, random gap, one long hold on request
	int rx_gap;
	int rx_hold;
	always @(posedge clk or negedge arst_n) begin
		nbc_pkg::result_t want;
		if (!arst_n) begin
			pop <= 0;
			rx_gap = 0;
			rx_hold = 0;
		end else begin
			if (pop && !empty) begin
				if (score_q.size() == 0) begin
					$error("unexpected result word");
					fails++;
				end else begin
					want = score_q.pop_front();
					if (result.male_score !== want.male_score) begin
						$error("male_score exp %h got %h", want.male_score, result.male_score);
						fails++;
					end
					if (result.female_score !== want.female_score) begin
						$error("female_score exp %h got %h", want.female_score,
							result.female_score);
						fails++;
					end
					if (result.no_data !== want.no_data) begin
						$error("no_data exp %b got %b", want.no_data, result.no_data);
						fails++;
					end
				end
				rx_gap = $urandom_range(0, 6);
				if ($urandom_range(0, 9) < 3) rx_gap = 0;
			end
			if (rx_hold_req) begin
				rx_hold_req = 0;
				rx_hold = LONG_HOLD;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				pop <= 0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				pop <= 0;
			end else begin
				pop <= 1;
			end
		end
	end

	// Cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic bit [7:0] pick_byte();
		bit [7:0] alpha [6] = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'h41, 8'h61};
		if ($urandom_range(0, 9) < 8) return alpha[$urandom_range(0, 5)];
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void add_word(bit [7:0] b, bit [7:0] g, bit l);
		nbc_pkg::item_t w;
		w.name_byte = b;
		w.gender_byte = g;
		w.last = l;
		name_q.push_back(w);
	endfunction

	// Queue one name of random bytes; gender drawn per word
	int words_sent;
	function automatic void add_name(int len);
		bit [7:0] g;
		for (int i = 0; i < len; i++) begin
			g = ($urandom_range(0, 1)) ? nbc_pkg::MALE_LABEL : 8'($urandom_range(0, 255));
			add_word(pick_byte(), g, i == len - 1);
		end
		words_sent += len;
	endfunction

	// Hold until the block has drained, then let it settle
	task automatic drain();
		wait (name_q.size() == 0 && !push && score_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_mode(bit v);
		drain();
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		cur_mode = v;
	endtask

	initial begin
		fails = 0;
		cycles = 0;
		words_sent = 0;
		tx_pause = 0;
		rx_hold_req = 0;
		cur_mode = 0;
		male_sum = 0;
		female_sum = 0;
		pend_byte = 0;
		pend_ok = 0;
		male_acc = 0;
		female_acc = 0;
		acc_live = 0;
		cfg_valid = 0;
		cfg_data = 0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;

		// Classify with nothing trained
		set_mode(1);
		add_word(8'h41, 8'h00, 0);
		add_word(8'hFF, 8'hFF, 1);
		add_word(8'h80, 8'h00, 1);

		// Train extremes, odd last byte, both classes
		set_mode(0);
		add_word(8'h00, 8'd208, 0); add_word(8'hFF, 8'd208, 1);
		add_word(8'h00, 8'h00, 0);  add_word(8'hFF, 8'hFF, 1);
		add_word(8'h80, 8'd208, 0); add_word(8'h7F, 8'd208, 0);
		add_word(8'hFF, 8'd207, 1);
		add_word(8'hFF, 8'h00, 1);  add_word(8'hFF, 8'd208, 1);
		add_word(8'h41, 8'd209, 0); // name left open across a mode change
		words_sent += 10;

		// Classify: finish the open name, predict-only words, odd byte
		set_mode(1);
		add_word(8'h61, 8'h00, 0); add_word(8'hFF, 8'h00, 1);
		add_word(8'h00, 8'h00, 0); add_word(8'hFF, 8'h00, 1);
		add_word(8'h00, 8'h00, 0); add_word(8'hFF, 8'h00, 0);
		add_word(8'h80, 8'h00, 0); add_word(8'h7F, 8'h00, 1);
		add_word(8'hFF, 8'h00, 0); // left open into training
		words_sent += 9;

		// Alternate random train and classify phases
		for (int ph = 0; words_sent < 1000; ph++) begin
			set_mode(ph[0]);
			if (ph == 3) rx_hold_req = 1;
			for (int n = 0; n < 30; n++) add_name($urandom_range(1, 6));
			if ($urandom_range(0, 1)) add_word(pick_byte(), 8'($urandom_range(0, 255)), 0);
			if (ph == 5) begin
				// Sender pause: wait until every result has come
				wait (name_q.size() < 40);
				tx_pause = 1;
				wait (!push && score_q.size() == 0);
				tx_pause = 0;
			end
		end

		set_mode(1);
		drain();
		if (fails == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
